@@ src/stq_pkg.sv @@
package stq_pkg;

    localparam int STQ_DEPTH = 16;

    localparam logic OP_ARM    = 1'b0;
    localparam logic OP_EXPIRE = 1'b1;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARM_FRONT,
        S_ARM_WALK,
        S_EXPIRE
    } t_state;

    typedef struct packed {
        logic [63:0] deadline;
        logic [15:0] handle;
    } t_entry;

    typedef struct packed {
        logic        kind;
        logic        status;
        logic [15:0] fired_handle;
        logic [63:0] fired_time;
        logic        reload_valid;
        logic [63:0] reload_delay;
        logic        last;
    } t_result;

endpackage

@@ src/sorted_timeout_queue.sv @@
// Deadline-sorted timeout queue of DEPTH entries held in a circular single-port-read
// memory. Arm stores now_time + delay in sorted order and answers with one acknowledge;
// an arm that becomes the new earliest entry (or finds the table empty) asks for a timer
// reload with its delay, and an arm into a full table is refused with status full.
// Expire reports every entry due at now_time, earliest first, and the last report carries
// the delay to the next remaining deadline when any entry remains. An arm that lands at the
// front or is refused needs no walk; otherwise the insertion walk moves each later entry
// back (at most DEPTH - 2 of them), reading and rewriting one entry per cycle. An expire
// does one memory read per due entry. Results wait in an output register; the block takes
// a new item once the previous one is done. The table needs no clearing after reset.
module sorted_timeout_queue
    import stq_pkg::*;
#(
    parameter int DEPTH = STQ_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_opcode,
    input  logic [63:0] i_now_time,
    input  logic [63:0] i_delay,
    input  logic [15:0] i_handle,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_kind,
    output logic        o_status,
    output logic [15:0] o_fired_handle,
    output logic [63:0] o_fired_time,
    output logic        o_reload_valid,
    output logic [63:0] o_reload_delay,
    output logic        o_last
);

    localparam int AW = $clog2(DEPTH);

    logic          res_valid;
    t_result       res;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_rdata;
    logic          r_out_valid;
    t_result       r_out;

    stq_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_now_time  (i_now_time),
        .i_delay     (i_delay),
        .i_handle    (i_handle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    stq_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_status       = r_out.status;
    assign o_fired_handle = r_out.fired_handle;
    assign o_fired_time   = r_out.fired_time;
    assign o_reload_valid = r_out.reload_valid;
    assign o_reload_delay = r_out.reload_delay;
    assign o_last         = r_out.last;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted but sequencer did not start");

    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_ACK) |-> o_last)
        else $error("acknowledge not marked last");

    a_reload_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reload_valid |-> o_last)
        else $error("reload request on a non-final result");

    a_full_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_FULL) |-> (o_kind == KIND_ACK) && !o_reload_valid)
        else $error("full status on a report or with reload");

endmodule

@@ src/stq_mem.sv @@
module stq_mem
    import stq_pkg::*;
#(
    parameter int DEPTH = STQ_DEPTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/stq_seq.sv @@
module stq_seq
    import stq_pkg::*;
#(
    parameter int DEPTH = STQ_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_opcode,
    input  logic [63:0]   i_now_time,
    input  logic [63:0]   i_delay,
    input  logic [15:0]   i_handle,
    output logic          o_res_valid,
    output t_result       o_res,
    input  logic          i_res_ready,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output t_entry        o_wdata,
    output logic [AW-1:0] o_raddr,
    input  t_entry        i_rdata
);

    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [AW-1:0] offs);
        logic [AW:0] sum;
        logic [AW:0] red;
        sum = {1'b0, base} + {1'b0, offs};
        red = sum - DEPTH_W;
        return (sum >= DEPTH_W) ? red[AW-1:0] : sum[AW-1:0];
    endfunction

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [15:0]   r_pend_handle, n_pend_handle;
    logic [63:0]   r_now, n_now;
    logic [63:0]   r_delay, n_delay;
    logic [15:0]   r_handle, n_handle;
    logic [63:0]   r_dl, n_dl;

    logic          accept;
    logic          is_full;
    logic          front_ins;
    logic          walk_move;
    logic          exp_due;
    logic          exp_hold;
    logic [AW-1:0] head_dec;
    logic [AW-1:0] head_inc;
    logic [CW-1:0] rd_logic;
    logic [63:0]   next_gap;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign is_full   = (r_count == DEPTH_C);
    assign front_ins = (r_count == '0) || (r_dl < i_rdata.deadline);
    assign walk_move = (r_idx >= CW'(2)) && !(i_rdata.deadline < r_dl);
    assign exp_due   = (r_count != '0) && !(r_now < i_rdata.deadline);
    assign exp_hold  = r_pend && !i_res_ready;
    assign head_dec  = (r_head == '0) ? LAST_A : r_head - AW'(1);
    assign head_inc  = f_phys(r_head, AW'(1));
    assign next_gap  = i_rdata.deadline - r_now;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_opcode == OP_ARM) ? S_ARM_FRONT : S_EXPIRE;
                end
            end
            S_ARM_FRONT: begin
                if (i_res_ready) begin
                    n_state = (is_full || front_ins) ? S_IDLE : S_ARM_WALK;
                end
            end
            S_ARM_WALK: begin
                if (!walk_move && i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_EXPIRE: begin
                if (!exp_hold && !exp_due) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count       = r_count;
        n_head        = r_head;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_pend_handle = r_pend_handle;
        n_now         = r_now;
        n_delay       = r_delay;
        n_handle      = r_handle;
        n_dl          = r_dl;
        o_we          = 1'b0;
        o_waddr       = '0;
        o_wdata       = '0;
        o_res_valid   = 1'b0;
        o_res         = '0;
        o_res.kind    = KIND_ACK;
        o_res.status  = STAT_OK;
        o_res.last    = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_now    = i_now_time;
                    n_delay  = i_delay;
                    n_handle = i_handle;
                    n_dl     = i_now_time + i_delay;
                    n_pend   = 1'b0;
                end
            end
            S_ARM_FRONT: begin
                if (i_res_ready) begin
                    if (is_full) begin
                        o_res_valid  = 1'b1;
                        o_res.status = STAT_FULL;
                    end else if (front_ins) begin
                        o_we                 = 1'b1;
                        o_waddr              = head_dec;
                        o_wdata.deadline     = r_dl;
                        o_wdata.handle       = r_handle;
                        n_head               = head_dec;
                        n_count              = r_count + CW'(1);
                        o_res_valid          = 1'b1;
                        o_res.reload_valid   = 1'b1;
                        o_res.reload_delay   = r_delay;
                    end else begin
                        n_idx = r_count;
                    end
                end
            end
            S_ARM_WALK: begin
                if (walk_move) begin
                    o_we    = 1'b1;
                    o_waddr = f_phys(r_head, r_idx[AW-1:0]);
                    o_wdata = i_rdata;
                    n_idx   = r_idx - CW'(1);
                end else if (i_res_ready) begin
                    o_we             = 1'b1;
                    o_waddr          = f_phys(r_head, r_idx[AW-1:0]);
                    o_wdata.deadline = r_dl;
                    o_wdata.handle   = r_handle;
                    n_count          = r_count + CW'(1);
                    o_res_valid      = 1'b1;
                end
            end
            S_EXPIRE: begin
                if (!exp_hold) begin
                    o_res.kind         = KIND_FIRE;
                    o_res.fired_handle = r_pend_handle;
                    o_res.fired_time   = r_now;
                    if (exp_due) begin
                        o_res_valid   = r_pend;
                        o_res.last    = 1'b0;
                        n_pend        = 1'b1;
                        n_pend_handle = i_rdata.handle;
                        n_head        = head_inc;
                        n_count       = r_count - CW'(1);
                    end else begin
                        o_res_valid        = r_pend;
                        o_res.reload_valid = (r_count != '0);
                        o_res.reload_delay = (r_count != '0) ? next_gap : '0;
                        n_pend             = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign rd_logic = (n_state == S_ARM_WALK) ? n_idx - CW'(1) : '0;
    assign o_raddr  = f_phys(n_head, rd_logic[AW-1:0]);
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_pend_handle <= n_pend_handle;
        r_now         <= n_now;
        r_delay       <= n_delay;
        r_handle      <= n_handle;
        r_dl          <= n_dl;
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb
    import stq_pkg::*;
();

    class timeout_checker;
        logic [63:0] due_at [STQ_DEPTH];
        logic [15:0] owner [STQ_DEPTH];
        int          armed;
        t_result     due_reports [$];
        int          errors;
        int          n_items;
        int          n_busy_items;
        int          n_results;
        int          n_full;
        int          n_fired;
        int          deepest;

        function new();
            armed        = 0;
            errors       = 0;
            n_items      = 0;
            n_busy_items = 0;
            n_results    = 0;
            n_full       = 0;
            n_fired      = 0;
            deepest      = 0;
        endfunction

        function void note_item(logic op, logic [63:0] now, logic [63:0] dly,
                                logic [15:0] hnd);
            t_result     r;
            logic [63:0] dl;
            int          pos;
            int          fired;
            int          i;
            n_items++;
            if (op == OP_ARM) begin
                r        = '0;
                r.kind   = KIND_ACK;
                r.status = STAT_OK;
                r.last   = 1'b1;
                n_busy_items++;
                if (armed >= STQ_DEPTH) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    dl = now + dly;
                    if (armed == 0 || dl < due_at[0]) begin
                        pos            = 0;
                        r.reload_valid = 1'b1;
                        r.reload_delay = dly;
                    end else begin
                        pos = 1;
                        while (pos < armed && due_at[pos] < dl)
                            pos++;
                    end
                    for (i = armed; i > pos; i--) begin
                        due_at[i] = due_at[i - 1];
                        owner[i]  = owner[i - 1];
                    end
                    due_at[pos] = dl;
                    owner[pos]  = hnd;
                    armed++;
                end
                due_reports.push_back(r);
            end else begin
                fired = 0;
                while (fired < armed && now >= due_at[fired])
                    fired++;
                if (fired > 0)
                    n_busy_items++;
                for (i = 0; i < fired; i++) begin
                    r              = '0;
                    r.kind         = KIND_FIRE;
                    r.status       = STAT_OK;
                    r.fired_handle = owner[i];
                    r.fired_time   = now;
                    r.last         = (i == fired - 1);
                    if (r.last && fired < armed) begin
                        r.reload_valid = 1'b1;
                        r.reload_delay = due_at[fired] - now;
                    end
                    due_reports.push_back(r);
                end
                for (i = 0; i < armed - fired; i++) begin
                    due_at[i] = due_at[i + fired];
                    owner[i]  = owner[i + fired];
                end
                armed   -= fired;
                n_fired += fired;
                if (fired > deepest)
                    deepest = fired;
            end
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            n_results++;
            if (due_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
            end else begin
                want = due_reports.pop_front();
                compare("kind", want.kind, got.kind);
                compare("status", want.status, got.status);
                compare("fired_handle", want.fired_handle, got.fired_handle);
                compare("fired_time", want.fired_time, got.fired_time);
                compare("reload_valid", want.reload_valid, got.reload_valid);
                compare("reload_delay", want.reload_delay, got.reload_delay);
                compare("last", want.last, got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_opcode;
    logic [63:0] i_now_time;
    logic [63:0] i_delay;
    logic [15:0] i_handle;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_kind;
    logic        o_status;
    logic [15:0] o_fired_handle;
    logic [63:0] o_fired_time;
    logic        o_reload_valid;
    logic [63:0] o_reload_delay;
    logic        o_last;

    t_result        seen;
    timeout_checker sb;
    int             tx_max    = 10;
    int             rx_max    = 10;
    int             long_hold = 0;

    sorted_timeout_queue u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_now_time     (i_now_time),
        .i_delay        (i_delay),
        .i_handle       (i_handle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_status       (o_status),
        .o_fired_handle (o_fired_handle),
        .o_fired_time   (o_fired_time),
        .o_reload_valid (o_reload_valid),
        .o_reload_delay (o_reload_delay),
        .o_last         (o_last)
    );

    assign seen = {o_kind, o_status, o_fired_handle, o_fired_time,
                   o_reload_valid, o_reload_delay, o_last};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("[sorted_timeout_queue] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_item(i_opcode, i_now_time, i_delay, i_handle);
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(seen);
    end

    // receiver: random stall per result, or one long hold-off on request
    initial begin
        int n;
        i_out_stall = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (long_hold > 0) begin
                n         = long_hold;
                long_hold = 0;
            end else begin
                n = $urandom_range(0, rx_max);
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_out_valid)
                @(posedge i_clk);
        end
    end

    task automatic offer(logic op, logic [63:0] now, logic [63:0] dly, logic [15:0] hnd);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_now_time <= now;
        i_delay    <= dly;
        i_handle   <= hnd;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    task automatic pause_until_empty();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_reports.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    initial begin
        logic [63:0] cur;
        logic [63:0] dly;
        int          target;
        int          e;
        int          arm_pct;
        int          len;
        int          roll;
        sb         = new();
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_opcode   = OP_ARM;
        i_now_time = '0;
        i_delay    = '0;
        i_handle   = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        offer(OP_EXPIRE, 64'd0, 64'd0, 16'h0000);
        offer(OP_ARM, 64'd1000, 64'd500, 16'h0001);
        offer(OP_ARM, 64'd1000, 64'd900, 16'h0002);
        offer(OP_ARM, 64'd1000, 64'd500, 16'h0003);
        offer(OP_ARM, 64'd1100, 64'd800, 16'h0004);
        offer(OP_ARM, 64'd1000, 64'd100, 16'hFFFF);
        offer(OP_EXPIRE, 64'd1050, 64'd0, 16'h0000);
        offer(OP_EXPIRE, 64'd1500, 64'd0, 16'h0000);
        offer(OP_ARM, 64'hFFFF_FFFF_FFFF_FF00, 64'h200, 16'h8001);
        offer(OP_EXPIRE, 64'h100, 64'd0, 16'h0000);
        offer(OP_ARM, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hA5A5);
        offer(OP_ARM, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'h5A5A);
        offer(OP_EXPIRE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        offer(OP_EXPIRE, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 16'h0000);
        offer(OP_ARM, 64'd5, 64'd0, 16'h0000);
        offer(OP_EXPIRE, 64'd5, 64'd0, 16'h0000);
        pause_until_empty();

        target = 430;
        e      = 0;
        while (sb.n_items < target) begin
            tx_max = (e % 5 == 4) ? 0 : 10;
            rx_max = (e % 5 == 2) ? 0 : 10;
            case ($urandom_range(0, 5))
                0, 1, 2: cur = 64'($urandom_range(0, 100000));
                3:       cur = rand64();
                default: cur = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000));
            endcase
            arm_pct = (e == 0) ? 95 : $urandom_range(40, 90);
            len     = (e == 0) ? 40 : $urandom_range(15, 40);
            if (len > target - sb.n_items)
                len = target - sb.n_items;
            if (e == 2) begin
                tx_max    = 0;
                long_hold = 300;
            end
            repeat (len) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    offer(1'($urandom_range(0, 1)), rand64(), rand64(),
                          16'($urandom_range(0, 65535)));
                end else if ($urandom_range(0, 99) < arm_pct) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: dly = 64'(100 * $urandom_range(0, 20));
                        6, 7:             dly = 64'($urandom_range(0, 5000));
                        8:                dly = '0;
                        default:          dly = rand64();
                    endcase
                    cur += 64'($urandom_range(0, 50));
                    offer(OP_ARM, cur, dly, 16'($urandom_range(0, 65535)));
                end else begin
                    cur += 64'($urandom_range(0, 1200));
                    offer(OP_EXPIRE, cur, rand64(), 16'($urandom_range(0, 65535)));
                end
            end
            if ($urandom_range(0, 3) == 0)
                pause_until_empty();
            e++;
        end

        pause_until_empty();
        repeat (40) @(posedge i_clk);
        sb.errors += sb.due_reports.size();
        $display("Run covered %0d items (%0d with results) and %0d results checked.",
                 sb.n_items, sb.n_busy_items, sb.n_results);
        $display("Arms refused on a full table: %0d; timeouts fired: %0d; largest batch: %0d.",
                 sb.n_full, sb.n_fired, sb.deepest);
        if (sb.errors == 0) begin
            $display("[sorted_timeout_queue] OK");
        end else begin
            $display("[sorted_timeout_queue] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/stq_pkg.sv
src/stq_mem.sv
src/stq_seq.sv
src/sorted_timeout_queue.sv
test/tb.sv
